// File: rtl/core/pptt_pkg.sv
package pptt_pkg;

  // Field and register widths.
  localparam int unsigned TEXT_W        = 8;
  localparam int unsigned PAGE_SIZE_W   = 21;
  localparam int unsigned KB_W          = 32;
  localparam int unsigned KB_SHIFT      = 10;
  localparam int unsigned TOTAL_PAGES_W = 32;
  localparam int unsigned TOTAL_W_DEF   = 32;

  // Reset value of the page size register.
  localparam logic [PAGE_SIZE_W-1:0] PAGE_SIZE_RST = PAGE_SIZE_W'(4096);

  // Characters the parser looks for.
  localparam logic [TEXT_W-1:0] CH_P       = 8'h50;
  localparam logic [TEXT_W-1:0] CH_R       = 8'h72;
  localparam logic [TEXT_W-1:0] CH_I       = 8'h69;
  localparam logic [TEXT_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [TEXT_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [TEXT_W-1:0] CH_NINE    = 8'h39;

  // Line parser phases.
  typedef enum logic [2:0] {
    PH_LINE_START = 3'd0,
    PH_SKIP_LINE  = 3'd1,
    PH_SAW_P      = 3'd2,
    PH_SAW_PR     = 3'd3,
    PH_PRIVATE    = 3'd4,
    PH_SIZE       = 3'd5
  } phase_t;

  // Sequencer states around the shared divider.
  typedef enum logic [1:0] {
    SEQ_IDLE = 2'd0,
    SEQ_DIV  = 2'd1,
    SEQ_ADD  = 2'd2
  } seq_t;

  // Control decoded from the sequencer state.
  typedef struct packed {
    logic idle;
    logic div_step;
    logic add_step;
  } seq_ctrl_t;

endpackage

// File: rtl/core/private_page_text_tally.sv
// Channel | Direction | Ports                                      | Beat
// --------+-----------+--------------------------------------------+--------------------------
// in      | input     | in_valid, in_stall, in_text_byte, in_restart | one text byte
// out     | output    | out_valid, out_stall, out_total_pages,     | one result per input beat
//         |           | out_number_closed                          |
// cfg     | input     | cfg_wr_en, cfg_wr_data                     | page size write
//
// A byte that does not end a number has its result registered directly. A byte that
// ends a number starts the restoring divider, which retires one quotient bit per
// cycle; then the add step adds the rounded quotient to the total.
// Synchronous active-low reset sets the line start phase, clears the counts and
// loads a page size of 4096. A stalled result holds in the output register; the
// input is stalled during the divide and add steps or while a held result blocks the next.
module private_page_text_tally #(
  parameter int unsigned TOTAL_WIDTH = pptt_pkg::TOTAL_W_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [pptt_pkg::PAGE_SIZE_W-1:0]     cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [pptt_pkg::TEXT_W-1:0]          in_text_byte,
  input  logic                                 in_restart,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [pptt_pkg::TOTAL_PAGES_W-1:0]   out_total_pages,
  output logic                                 out_number_closed
);
  import pptt_pkg::*;

  localparam int unsigned QW    = KB_W + KB_SHIFT;
  localparam int unsigned BW    = QW + 1;
  localparam int unsigned SW    = ((TOTAL_WIDTH > BW) ? TOTAL_WIDTH : BW) + 1;
  localparam int unsigned CNT_W = $clog2(QW);
  localparam int unsigned RW    = PAGE_SIZE_W;

  logic [PAGE_SIZE_W-1:0]   page_size_r;
  phase_t                   phase_r, phase_nxt;
  logic [KB_W-1:0]          kb_r, kb_nxt;
  logic [TOTAL_WIDTH-1:0]   total_r, total_nxt;
  seq_t                     seq_r, seq_nxt;
  seq_ctrl_t                ctrl;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [QW-1:0]            quo_r, quo_nxt;
  logic [RW-1:0]            rem_r, rem_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [TOTAL_PAGES_W-1:0] out_total_r, out_total_nxt;
  logic                     out_closed_r, out_closed_nxt;

  logic                     out_free;
  logic                     in_fire;
  logic                     is_digit;
  logic [3:0]               digit_val;
  phase_t                   phase_eff;
  logic [KB_W-1:0]          kb_eff;
  logic [TOTAL_WIDTH-1:0]   total_eff;
  logic [KB_W+3:0]          kb_acc;
  logic [KB_W-1:0]          kb_digit;
  logic                     closes;
  logic [PAGE_SIZE_W-1:0]   ps_eff;
  logic [RW:0]              rem_shift;
  logic [RW:0]              rem_trial;
  logic                     rem_ge;
  logic [BW-1:0]            blocks;
  logic [SW-1:0]            sum;
  logic [TOTAL_WIDTH-1:0]   sum_sat;
  logic [TOTAL_WIDTH+TOTAL_PAGES_W-1:0] total_ext;
  logic [TOTAL_WIDTH+TOTAL_PAGES_W-1:0] sum_ext;

  // Handshakes.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !ctrl.idle || !out_free;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid         = out_valid_r;
  assign out_total_pages   = out_total_r;
  assign out_number_closed = out_closed_r;

  // Restart clears the parser and totals before the byte is handled.
  assign phase_eff = in_restart ? PH_LINE_START : phase_r;
  assign kb_eff    = in_restart ? '0 : kb_r;
  assign total_eff = in_restart ? '0 : total_r;

  // Digit decode and saturating decimal accumulate (value * 10 + digit).
  assign is_digit  = (in_text_byte >= CH_ZERO) && (in_text_byte <= CH_NINE);
  assign digit_val = 4'(in_text_byte - CH_ZERO);
  assign kb_acc    = ({4'b0, kb_eff} << 3) + ({4'b0, kb_eff} << 1)
                     + {{(KB_W){1'b0}}, digit_val};
  assign kb_digit  = (kb_acc[KB_W+3:KB_W] != 4'b0) ? '1 : kb_acc[KB_W-1:0];

  // Line parser: next phase and kilobyte value for the incoming byte.
  always_comb begin
    phase_nxt = phase_r;
    kb_nxt    = kb_r;
    closes    = 1'b0;
    if (in_fire) begin
      kb_nxt = kb_eff;
      unique case (phase_eff)
        PH_LINE_START: begin
          phase_nxt = (in_text_byte == CH_P) ? PH_SAW_P : PH_SKIP_LINE;
        end
        PH_SAW_P: begin
          phase_nxt = (in_text_byte == CH_R) ? PH_SAW_PR : PH_SKIP_LINE;
        end
        PH_SAW_PR: begin
          phase_nxt = (in_text_byte == CH_I) ? PH_PRIVATE : PH_SKIP_LINE;
        end
        PH_PRIVATE: begin
          if (is_digit) begin
            kb_nxt    = KB_W'(digit_val);
            phase_nxt = PH_SIZE;
          end else if (in_text_byte == CH_NEWLINE) begin
            phase_nxt = PH_LINE_START;
          end else begin
            phase_nxt = PH_PRIVATE;
          end
        end
        PH_SIZE: begin
          if (is_digit) begin
            kb_nxt    = kb_digit;
            phase_nxt = PH_SIZE;
          end else begin
            closes    = 1'b1;
            phase_nxt = (in_text_byte == CH_NEWLINE) ? PH_LINE_START : PH_SKIP_LINE;
          end
        end
        default: begin
          phase_nxt = (in_text_byte == CH_NEWLINE) ? PH_LINE_START : PH_SKIP_LINE;
        end
      endcase
    end else if (ctrl.add_step && out_free) begin
      // The closed number is consumed once its pages are added.
      kb_nxt = '0;
    end
  end

  // Sequencer next state.
  always_comb begin
    seq_nxt = seq_r;
    unique case (seq_r)
      SEQ_IDLE: if (in_fire && closes) seq_nxt = SEQ_DIV;
      SEQ_DIV:  if (cnt_r == CNT_W'(QW - 1)) seq_nxt = SEQ_ADD;
      SEQ_ADD:  if (out_free) seq_nxt = SEQ_IDLE;
      default:  seq_nxt = SEQ_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    ctrl = '0;
    unique case (seq_r)
      SEQ_IDLE: ctrl.idle     = 1'b1;
      SEQ_DIV:  ctrl.div_step = 1'b1;
      SEQ_ADD:  ctrl.add_step = 1'b1;
      default:  ctrl.idle     = 1'b1;
    endcase
  end

  // Shared restoring divider step: one quotient bit per cycle.
  assign ps_eff    = (page_size_r == '0) ? PAGE_SIZE_W'(1) : page_size_r;
  assign rem_shift = {rem_r, quo_r[QW-1]};
  assign rem_trial = rem_shift - {1'b0, ps_eff};
  assign rem_ge    = rem_shift >= {1'b0, ps_eff};

  always_comb begin
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    if (in_fire && closes) begin
      cnt_nxt = '0;
      quo_nxt = {kb_eff, {(KB_SHIFT){1'b0}}};
      rem_nxt = '0;
    end else if (ctrl.div_step) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      quo_nxt = {quo_r[QW-2:0], rem_ge};
      rem_nxt = rem_ge ? rem_trial[RW-1:0] : rem_shift[RW-1:0];
    end
  end

  // Rounded-up quotient and saturating total.
  assign blocks  = {1'b0, quo_r} + {{(BW-1){1'b0}}, (rem_r != '0)};
  assign sum     = SW'(total_r) + SW'(blocks);
  assign sum_sat = (sum[SW-1:TOTAL_WIDTH] != '0) ? '1 : sum[TOTAL_WIDTH-1:0];
  assign total_ext = {{(TOTAL_PAGES_W){1'b0}}, total_eff};
  assign sum_ext   = {{(TOTAL_PAGES_W){1'b0}}, sum_sat};

  always_comb begin
    total_nxt = total_r;
    if (in_fire) begin
      total_nxt = total_eff;
    end else if (ctrl.add_step && out_free) begin
      total_nxt = sum_sat;
    end
  end

  // Output register: filled at once for plain bytes, after the add otherwise.
  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_total_nxt  = out_total_r;
    out_closed_nxt = out_closed_r;
    if (in_fire && !closes) begin
      out_valid_nxt  = 1'b1;
      out_total_nxt  = total_ext[TOTAL_PAGES_W-1:0];
      out_closed_nxt = 1'b0;
    end else if (ctrl.add_step && out_free) begin
      out_valid_nxt  = 1'b1;
      out_total_nxt  = sum_ext[TOTAL_PAGES_W-1:0];
      out_closed_nxt = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_size_r <= PAGE_SIZE_RST;
      phase_r     <= PH_LINE_START;
      kb_r        <= '0;
      total_r     <= '0;
      seq_r       <= SEQ_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        page_size_r <= cfg_wr_data;
      end
      phase_r     <= phase_nxt;
      kb_r        <= kb_nxt;
      total_r     <= total_nxt;
      seq_r       <= seq_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    out_total_r  <= out_total_nxt;
    out_closed_r <= out_closed_nxt;
  end

endmodule

// File: tb/tb.sv
import pptt_pkg::*;

// One expected result beat: the running page count and the number-end flag.
typedef struct packed {
  logic [TOTAL_PAGES_W-1:0] pages;
  logic                     closed;
} page_result_t;

// Tracks the line parser and page total, and checks each result beat in order.
class page_tally_book;
  phase_t                   phase;
  bit [63:0]                kb_count;
  bit [63:0]                page_sum;
  bit [PAGE_SIZE_W-1:0]     page_bytes;
  page_result_t             awaited[$];
  int                       mismatches;
  int                       numbers_closed;
  int                       bytes_seen;

  function new();
    phase          = PH_LINE_START;
    kb_count       = '0;
    page_sum       = '0;
    page_bytes     = PAGE_SIZE_RST;
    mismatches     = 0;
    numbers_closed = 0;
    bytes_seen     = 0;
  endfunction

  function void set_page_size(bit [PAGE_SIZE_W-1:0] value);
    page_bytes = value;
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  // Append one decimal digit; the kilobyte count sticks at its 32-bit maximum.
  function void add_digit(bit [TEXT_W-1:0] ch);
    bit [63:0] grown;
    grown    = kb_count * 64'd10 + 64'(ch - CH_ZERO);
    kb_count = (grown > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : grown;
  endfunction

  // Convert kilobytes to pages, rounding up, and add to the saturating total.
  function void close_number();
    bit [63:0] divisor;
    bit [63:0] byte_count;
    bit [63:0] pages;
    bit [63:0] cap;
    divisor    = (page_bytes == 0) ? 64'd1 : 64'(page_bytes);
    byte_count = kb_count << KB_SHIFT;
    pages      = (byte_count + divisor - 64'd1) / divisor;
    cap        = (TOTAL_W_DEF >= 64) ? '1 : (64'd1 << TOTAL_W_DEF) - 64'd1;
    if (page_sum > cap || pages > cap - page_sum) begin
      page_sum = cap;
    end else begin
      page_sum = page_sum + pages;
    end
    kb_count = '0;
  endfunction

  // Step the parser by one accepted text beat and queue the result it causes.
  function void note_byte(bit [TEXT_W-1:0] ch, bit clear);
    bit           is_digit;
    bit           closed;
    page_result_t r;
    is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    closed   = 1'b0;
    if (clear) begin
      phase    = PH_LINE_START;
      kb_count = '0;
      page_sum = '0;
    end
    case (phase)
      PH_LINE_START: begin
        phase = (ch == CH_P) ? PH_SAW_P : PH_SKIP_LINE;
      end
      PH_SAW_P: begin
        phase = (ch == CH_R) ? PH_SAW_PR : PH_SKIP_LINE;
      end
      PH_SAW_PR: begin
        phase = (ch == CH_I) ? PH_PRIVATE : PH_SKIP_LINE;
      end
      PH_PRIVATE: begin
        if (is_digit) begin
          kb_count = '0;
          add_digit(ch);
          phase = PH_SIZE;
        end else if (ch == CH_NEWLINE) begin
          phase = PH_LINE_START;
        end
      end
      PH_SIZE: begin
        if (is_digit) begin
          add_digit(ch);
        end else begin
          close_number();
          closed = 1'b1;
          numbers_closed++;
          phase = (ch == CH_NEWLINE) ? PH_LINE_START : PH_SKIP_LINE;
        end
      end
      default: begin
        phase = (ch == CH_NEWLINE) ? PH_LINE_START : PH_SKIP_LINE;
      end
    endcase
    r.pages  = page_sum[TOTAL_PAGES_W-1:0];
    r.closed = closed;
    awaited.push_back(r);
    bytes_seen++;
  endfunction

  // Compare one accepted result beat with the oldest expectation.
  function void check_result(logic [TOTAL_PAGES_W-1:0] pages, logic closed,
                             longint unsigned stamp);
    page_result_t want;
    if (awaited.size() == 0) begin
      mismatches++;
      $display("%0d ns: unexpected result: expected none, actual total_pages=%0d closed=%0b",
               stamp, pages, closed);
      return;
    end
    want = awaited.pop_front();
    if (pages !== want.pages) begin
      mismatches++;
      $display("%0d ns: total_pages mismatch: expected %0d, actual %0d",
               stamp, want.pages, pages);
    end
    if (closed !== want.closed) begin
      mismatches++;
      $display("%0d ns: number_closed mismatch: expected %0b, actual %0b",
               stamp, want.closed, closed);
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [TEXT_W-1:0] text_q_t[$];

  logic                     clk          = 1'b0;
  logic                     rst_n        = 1'b0;
  logic                     cfg_wr_en    = 1'b0;
  logic [PAGE_SIZE_W-1:0]   cfg_wr_data  = '0;
  logic                     in_valid     = 1'b0;
  logic                     in_stall;
  logic [TEXT_W-1:0]        in_text_byte = '0;
  logic                     in_restart   = 1'b0;
  logic                     out_valid;
  logic                     out_stall    = 1'b0;
  logic [TOTAL_PAGES_W-1:0] out_total_pages;
  logic                     out_number_closed;

  bit feed_pauses  = 1'b0;
  bit drain_pauses = 1'b0;
  int stall_left   = 0;
  int sizes_used   = 0;

  page_tally_book book = new();

  private_page_text_tally dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_text_byte      (in_text_byte),
    .in_restart        (in_restart),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_total_pages   (out_total_pages),
    .out_number_closed (out_number_closed)
  );

  always #4 clk = ~clk;

  // Result-side backpressure comes in random bursts while drain pauses are on.
  always @(posedge clk) begin
    if (!drain_pauses) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 18);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Every result beat taken at a clock edge is checked against the predictor.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      book.check_result(out_total_pages, out_number_closed, $time);
    end
  end

  // Offer one text beat, possibly after an idle burst, and wait for it to be taken.
  task automatic send_byte(input logic [TEXT_W-1:0] ch, input logic clear);
    if (feed_pauses && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= ch;
    in_restart   <= clear;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_byte(ch, clear);
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_byte(s[k], 1'b0);
  endtask

  // Random restarts land anywhere inside a line, rarely.
  task automatic send_line(input text_q_t txt);
    foreach (txt[k]) send_byte(txt[k], $urandom_range(0, 59) == 0);
  endtask

  // Page size changes only once every result has come back.
  task automatic write_page_size(input logic [PAGE_SIZE_W-1:0] value);
    while (book.pending() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    book.set_page_size(value);
    sizes_used++;
  endtask

  // Any byte that is neither a digit nor a newline.
  function automatic logic [TEXT_W-1:0] filler_byte();
    logic [TEXT_W-1:0] ch;
    do begin
      ch = TEXT_W'($urandom_range(0, 255));
    end while ((ch >= CH_ZERO && ch <= CH_NINE) || ch == CH_NEWLINE);
    return ch;
  endfunction

  // Mostly well-formed private size lines, with broken prefixes and noise mixed in.
  task automatic send_random_line();
    text_q_t txt;
    int      kind;
    int      n;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      txt.push_back(CH_P);
      txt.push_back(CH_R);
      txt.push_back(CH_I);
      repeat ($urandom_range(0, 4)) txt.push_back(filler_byte());
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 6);
      repeat (n) txt.push_back(CH_ZERO + TEXT_W'($urandom_range(0, 9)));
      if ($urandom_range(0, 1) == 0) begin
        txt.push_back(CH_NEWLINE);
      end else begin
        txt.push_back(" ");
        txt.push_back("k");
        txt.push_back("B");
        txt.push_back(CH_NEWLINE);
      end
    end else if (kind < 78) begin
      // A newline at line start makes the following line be skipped.
      txt.push_back(CH_NEWLINE);
    end else if (kind < 88) begin
      // A prefix that breaks off, or a private line with no number on it.
      n = $urandom_range(0, 2);
      txt.push_back(CH_P);
      if (n >= 1) txt.push_back(CH_R);
      if (n == 2) begin
        txt.push_back(CH_I);
        repeat ($urandom_range(0, 3)) txt.push_back(filler_byte());
      end else begin
        txt.push_back(filler_byte());
      end
      txt.push_back(CH_NEWLINE);
    end else begin
      repeat ($urandom_range(1, 8)) txt.push_back(TEXT_W'($urandom_range(0, 255)));
      txt.push_back(CH_NEWLINE);
    end
    send_line(txt);
  endtask

  initial begin
    int target;
    logic [PAGE_SIZE_W-1:0] size_now;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines under a zero page size, which counts as one byte per page.
    feed_pauses  = 1'b1;
    drain_pauses = 1'b1;
    write_page_size('0);
    send_text("\nPri5\n");
    send_text("Pri/:");
    send_byte(8'hFF, 1'b0);
    send_text("9999999999\n");
    send_byte(CH_P, 1'b1);
    send_text("ri0 ");
    in_valid <= 1'b0;

    // Random text under a series of page sizes; the last stretch runs without pauses.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: size_now = PAGE_SIZE_W'(3);
        1: size_now = PAGE_SIZE_W'(4096);
        2: size_now = PAGE_SIZE_W'(1);
        3: size_now = PAGE_SIZE_W'(1048576);
        4: size_now = '1;
        default: size_now = PAGE_SIZE_W'($urandom_range(1, 1048576));
      endcase
      write_page_size(size_now);
      feed_pauses  = (p != 2) && (p != 5);
      drain_pauses = (p != 1) && (p != 5);
      target = book.bytes_seen + 65;
      while (book.bytes_seen < target) send_random_line();
      in_valid <= 1'b0;
    end

    // A number cut off by the end of the stream is never counted.
    send_text("Pri12");
    in_valid <= 1'b0;

    for (int w = 0; w < 20000 && book.pending() != 0; w++) @(posedge clk);
    repeat (60) @(posedge clk);
    if (book.pending() != 0) begin
      book.mismatches += book.pending();
      $display("%0d ns: %0d expected results never arrived", $time, book.pending());
    end

    $display("Covered %0d text beats and %0d closed size numbers over %0d page sizes.",
             book.bytes_seen, book.numbers_closed, sizes_used);
    $display("Mismatches found: %0d.", book.mismatches);
    if (book.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4_000_000;
    $display("Run timed out.");
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// File: files.f
rtl/core/pptt_pkg.sv
rtl/core/private_page_text_tally.sv
tb/tb.sv
